@@ rtl/core/tsp_pkg.sv @@
`default_nettype none
package tsp_pkg;

    localparam int BLOCK_BYTES  = 512;
    localparam int SIZE_BITS    = 48;
    localparam int QUEUE_DEPTH  = 4;
    localparam int FIELD_BITS   = 48;

    localparam logic [1:0] KIND_ENTRY = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BOUNDS   = 3'd1;
    localparam logic [2:0] ERR_NO_END   = 3'd2;
    localparam logic [2:0] ERR_CHECKSUM = 3'd3;
    localparam logic [2:0] ERR_MAGIC    = 3'd4;
    localparam logic [2:0] ERR_PAX      = 3'd5;
    localparam logic [2:0] ERR_TYPE     = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_word;

    typedef struct packed {
        logic [1:0]            event_kind;
        logic [3:0]            entry_type;
        logic [FIELD_BITS-1:0] entry_size;
        logic [FIELD_BITS-1:0] data_offset;
        logic [2:0]            error_code;
        logic                  is_final;
    } t_out_word;

    typedef struct packed {
        logic [1:0] count;
        t_out_word  ev0;
        t_out_word  ev1;
    } t_push;

endpackage
`default_nettype wire

@@ rtl/core/tsp_front.sv @@
`default_nettype none
module tsp_front #(
    parameter int SIZE_BITS = tsp_pkg::SIZE_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire tsp_pkg::t_in_word i_word,
    output tsp_pkg::t_push         o_push
);
    localparam int FB = tsp_pkg::FIELD_BITS;
    localparam logic [SIZE_BITS-1:0] SZ_MAX = {SIZE_BITS{1'b1}};
    localparam logic [23:0] LEN_MAX = 24'hFFFFFF;
    localparam logic [8:0] LAST_IDX = 9'(tsp_pkg::BLOCK_BYTES - 1);

    typedef enum logic [2:0] {
        PH_HEADER, PH_SKIP, PH_PAXLEN, PH_PAXKEY, PH_PAXVAL, PH_ENDCHK
    } t_phase;

    t_phase                r_phase, n_phase;
    logic [8:0]            r_idx, n_idx;
    logic [47:0]           r_off, n_off;
    logic [16:0]           r_sum, n_sum;
    logic [23:0]           r_chk, n_chk;
    logic [SIZE_BITS-1:0]  r_hsize, n_hsize;
    logic [3:0]            r_flags, n_flags;
    logic                  r_chk_st, n_chk_st, r_size_st, n_size_st;
    logic [7:0]            r_type, n_type;
    logic [SIZE_BITS-1:0]  r_skip, n_skip;
    logic [SIZE_BITS-1:0]  r_pad, n_pad;
    logic [23:0]           r_len, n_len;
    logic [23:0]           r_dig, n_dig;
    logic [2:0]            r_km, n_km;
    logic [SIZE_BITS-1:0]  r_val, n_val;
    logic [SIZE_BITS-1:0]  r_local, n_local;
    logic [SIZE_BITS-1:0]  r_global, n_global;
    logic                  r_halted, n_halted;

    function automatic logic [SIZE_BITS-1:0] sat8(input logic [SIZE_BITS-1:0] a,
                                                  input logic [3:0] d);
        logic [SIZE_BITS+3:0] w;
        w = {1'b0, a, 3'b000} + (SIZE_BITS+4)'(d);
        return (w > (SIZE_BITS+4)'(SZ_MAX)) ? SZ_MAX : w[SIZE_BITS-1:0];
    endfunction

    function automatic logic [SIZE_BITS-1:0] sat10(input logic [SIZE_BITS-1:0] a,
                                                   input logic [3:0] d);
        logic [SIZE_BITS+3:0] w;
        w = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + (SIZE_BITS+4)'(d);
        return (w > (SIZE_BITS+4)'(SZ_MAX)) ? SZ_MAX : w[SIZE_BITS-1:0];
    endfunction

    function automatic logic [7:0] magic_char(input logic [8:0] i);
        case (i)
            9'd257:  return 8'h75;
            9'd258:  return 8'h73;
            9'd259:  return 8'h74;
            9'd260:  return 8'h61;
            9'd261:  return 8'h72;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] key_char(input logic [2:0] i);
        case (i)
            3'd0:    return 8'h73;
            3'd1:    return 8'h69;
            3'd2:    return 8'h7A;
            3'd3:    return 8'h65;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [FB-1:0] to_field(input logic [SIZE_BITS-1:0] v);
        logic [63:0] t;
        t = 64'(v);
        return t[FB-1:0];
    endfunction

    logic [7:0] b;
    logic       is_sp, is_oct, is_dig;
    logic [3:0] dv;
    logic       enter, perr, do_commit;
    t_phase     enter_phase;
    logic [2:0] c_km;
    logic [SIZE_BITS-1:0] c_val;
    logic [2:0] err;
    logic [1:0] k;
    tsp_pkg::t_out_word ev [2];
    logic [SIZE_BITS-1:0] rnd_in, rnd_out, sel_size;
    logic [SIZE_BITS:0]   rnd_sum;
    logic [24:0] used;
    logic [23:0] lenm;
    logic [27:0] lw;

    // block round-up, saturating at the size maximum
    always_comb begin
        rnd_sum = {1'b0, rnd_in} + (SIZE_BITS+1)'(10'd512 - {1'b0, rnd_in[8:0]});
        if (rnd_in[8:0] == 9'd0) begin
            rnd_out = rnd_in;
        end else if (rnd_sum > (SIZE_BITS+1)'(SZ_MAX)) begin
            rnd_out = SZ_MAX;
        end else begin
            rnd_out = rnd_sum[SIZE_BITS-1:0];
        end
    end

    always_comb begin
        n_phase = r_phase;   n_idx = r_idx;       n_off = r_off;
        n_sum = r_sum;       n_chk = r_chk;       n_hsize = r_hsize;
        n_flags = r_flags;   n_chk_st = r_chk_st; n_size_st = r_size_st;
        n_type = r_type;     n_skip = r_skip;     n_pad = r_pad;
        n_len = r_len;       n_dig = r_dig;       n_km = r_km;
        n_val = r_val;       n_local = r_local;   n_global = r_global;
        n_halted = r_halted;
        b = i_word.data_byte;
        is_sp = (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
        is_oct = (b >= 8'h30 && b <= 8'h37);
        is_dig = (b >= 8'h30 && b <= 8'h39);
        dv = 4'(b - 8'h30);
        enter = 1'b0;
        enter_phase = PH_HEADER;
        perr = 1'b0;
        do_commit = 1'b0;
        c_km = r_km;
        c_val = r_val;
        err = tsp_pkg::ERR_NONE;
        k = 2'd0;
        ev[0] = '0;
        ev[1] = '0;
        used = 25'(r_dig) + 25'd1;
        lenm = r_len - 24'd1;
        lw = 28'd0;
        sel_size = (r_local != '0) ? r_local : (r_global != '0) ? r_global : r_hsize;
        rnd_in = sel_size;

        if (i_accept && !r_halted) begin
            n_off = r_off + 48'd1;
            case (r_phase)
                PH_HEADER, PH_ENDCHK: begin
                    if (b != 8'd0) n_flags[0] = 1'b1;
                    if (r_idx >= 9'd148 && r_idx < 9'd156) begin
                        n_sum = r_sum + 17'd32;
                        if (!r_flags[2] && !(!r_chk_st && is_sp)) begin
                            if (is_oct) begin
                                n_chk_st = 1'b1;
                                lw = {1'b0, r_chk, 3'b000} + 28'(dv);
                                n_chk = (lw > 28'(LEN_MAX)) ? LEN_MAX : lw[23:0];
                            end else begin
                                n_flags[2] = 1'b1;
                            end
                        end
                    end else begin
                        n_sum = r_sum + 17'(b);
                    end
                    if (r_idx >= 9'd124 && r_idx < 9'd136) begin
                        if (!r_flags[3] && !(!r_size_st && is_sp)) begin
                            if (is_oct) begin
                                n_size_st = 1'b1;
                                n_hsize = sat8(r_hsize, dv);
                            end else begin
                                n_flags[3] = 1'b1;
                            end
                        end
                    end
                    if (r_idx == 9'd156) n_type = b;
                    if (r_idx >= 9'd257 && r_idx < 9'd263 && b != magic_char(r_idx)) begin
                        n_flags[1] = 1'b1;
                    end
                    if (n_type == 8'h78 || n_type == 8'h67) rnd_in = n_hsize;

                    if (r_idx < LAST_IDX) begin
                        n_idx = r_idx + 9'd1;
                    end else if (r_phase == PH_ENDCHK) begin
                        if (n_flags[0]) begin
                            err = tsp_pkg::ERR_NO_END;
                        end else begin
                            ev[0].event_kind = tsp_pkg::KIND_END;
                            k = 2'd1;
                        end
                        n_halted = 1'b1;
                    end else if (!n_flags[0]) begin
                        enter = 1'b1;
                        enter_phase = PH_ENDCHK;
                    end else if (24'(n_sum) != n_chk) begin
                        err = tsp_pkg::ERR_CHECKSUM;
                    end else if (n_flags[1]) begin
                        err = tsp_pkg::ERR_MAGIC;
                    end else if (n_type == 8'h78 || n_type == 8'h67) begin
                        n_skip = rnd_out;
                        n_pad = rnd_out - n_hsize;
                        n_phase = PH_PAXLEN;
                        n_len = '0; n_val = '0; n_km = '0; n_dig = '0;
                        if (rnd_out == '0) enter = 1'b1;
                    end else if (n_type >= 8'h30 && n_type <= 8'h39) begin
                        ev[0].event_kind = tsp_pkg::KIND_ENTRY;
                        ev[0].entry_type = 4'(n_type - 8'h30);
                        ev[0].entry_size = to_field(sel_size);
                        ev[0].data_offset = n_off;
                        k = 2'd1;
                        n_local = '0;
                        n_skip = rnd_out;
                        if (rnd_out == '0) enter = 1'b1;
                        else n_phase = PH_SKIP;
                    end else begin
                        err = tsp_pkg::ERR_TYPE;
                    end
                end
                PH_SKIP: begin
                    n_skip = r_skip - SIZE_BITS'(1);
                    if (n_skip == '0) enter = 1'b1;
                end
                default: begin
                    case (r_phase)
                        PH_PAXLEN: begin
                            if (is_dig) begin
                                lw = {1'b0, r_len, 3'b000} + {3'b000, r_len, 1'b0} + 28'(dv);
                                n_len = (lw > 28'(LEN_MAX)) ? LEN_MAX : lw[23:0];
                                if (r_dig < LEN_MAX) n_dig = r_dig + 24'd1;
                            end else if (used >= 25'(r_len)) begin
                                perr = 1'b1;
                            end else begin
                                n_len = r_len - used[23:0];
                                n_dig = '0; n_val = '0; n_km = '0;
                                n_phase = PH_PAXKEY;
                            end
                        end
                        PH_PAXKEY: begin
                            n_len = lenm;
                            if (b == 8'h3D) begin
                                n_km = (r_km == 3'd4) ? 3'd4 : 3'd5;
                                n_val = '0;
                                n_phase = PH_PAXVAL;
                                if (lenm == 24'd0) begin
                                    do_commit = 1'b1;
                                    c_km = n_km;
                                    c_val = '0;
                                    n_phase = PH_PAXLEN;
                                    n_len = '0; n_val = '0; n_km = '0; n_dig = '0;
                                end
                            end else begin
                                if (r_km < 3'd4 && b == key_char(r_km)) n_km = r_km + 3'd1;
                                else n_km = 3'd5;
                                if (lenm == 24'd0) perr = 1'b1;
                            end
                        end
                        default: begin
                            if (r_km == 3'd4) begin
                                if (is_dig) n_val = sat10(r_val, dv);
                                else n_km = 3'd6;
                            end
                            n_len = lenm;
                            if (lenm == 24'd0) begin
                                do_commit = 1'b1;
                                c_km = n_km;
                                c_val = n_val;
                                n_phase = PH_PAXLEN;
                                n_len = '0; n_val = '0; n_km = '0; n_dig = '0;
                            end
                        end
                    endcase
                    n_skip = r_skip - SIZE_BITS'(1);
                    if (!perr && n_skip == r_pad) begin
                        if (n_phase == PH_PAXKEY) begin
                            perr = 1'b1;
                        end else if (n_phase == PH_PAXLEN && n_dig != '0) begin
                            perr = 1'b1;
                        end else begin
                            if (n_phase == PH_PAXVAL) begin
                                do_commit = 1'b1;
                                c_km = n_km;
                                c_val = n_val;
                            end
                            if (r_pad == '0) begin
                                enter = 1'b1;
                            end else begin
                                n_phase = PH_SKIP;
                                n_skip = r_pad;
                            end
                        end
                    end
                    if (perr) err = tsp_pkg::ERR_PAX;
                    if (do_commit && (c_km == 3'd4 || c_km == 3'd6)) begin
                        if (r_type == 8'h78) n_local = c_val;
                        else n_global = c_val;
                    end
                end
            endcase

            if (enter) begin
                n_phase = enter_phase;
                n_idx = '0; n_sum = '0; n_chk = '0; n_hsize = '0;
                n_flags = '0; n_chk_st = 1'b0; n_size_st = 1'b0; n_type = '0;
            end
            if (err != tsp_pkg::ERR_NONE) begin
                ev[k[0]].event_kind = tsp_pkg::KIND_ERROR;
                ev[k[0]].error_code = err;
                k = k + 2'd1;
                n_halted = 1'b1;
            end
            if (!n_halted && i_word.is_last) begin
                ev[k[0]].event_kind = tsp_pkg::KIND_ERROR;
                ev[k[0]].error_code = tsp_pkg::ERR_BOUNDS;
                k = k + 2'd1;
                n_halted = 1'b1;
            end
            if (k == 2'd1) ev[0].is_final = 1'b1;
            if (k == 2'd2) ev[1].is_final = 1'b1;
        end
        o_push.count = k;
        o_push.ev0 = ev[0];
        o_push.ev1 = ev[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_idx <= '0;    r_off <= '0;
            r_sum <= '0;         r_chk <= '0;     r_hsize <= '0;
            r_flags <= '0;       r_chk_st <= 1'b0; r_size_st <= 1'b0;
            r_type <= '0;        r_skip <= '0;    r_pad <= '0;
            r_len <= '0;         r_dig <= '0;     r_km <= '0;
            r_val <= '0;         r_local <= '0;   r_global <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase <= n_phase;  r_idx <= n_idx;  r_off <= n_off;
            r_sum <= n_sum;      r_chk <= n_chk;  r_hsize <= n_hsize;
            r_flags <= n_flags;  r_chk_st <= n_chk_st; r_size_st <= n_size_st;
            r_type <= n_type;    r_skip <= n_skip; r_pad <= n_pad;
            r_len <= n_len;      r_dig <= n_dig;  r_km <= n_km;
            r_val <= n_val;      r_local <= n_local; r_global <= n_global;
            r_halted <= n_halted;
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/tsp_queue.sv @@
`default_nettype none
module tsp_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tsp_pkg::t_push     i_push,
    input  wire logic               i_pop,
    output tsp_pkg::t_out_word      o_data,
    output logic                    o_valid,
    output logic                    o_no_room
);
    localparam int D  = tsp_pkg::QUEUE_DEPTH;
    localparam int PW = $clog2(D);

    tsp_pkg::t_out_word r_mem [D];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;
    logic [PW-1:0] wp1;

    assign wp1 = r_wp + PW'(1);
    assign o_data = r_mem[r_rp];
    assign o_valid = (r_cnt != '0);
    // keep room for the two words one byte can cause
    assign o_no_room = (r_cnt > (PW+1)'(D - 2));

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wp] <= i_push.ev0;
        if (i_push.count == 2'd2) r_mem[wp1] <= i_push.ev1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            r_wp <= r_wp + PW'(i_push.count);
            if (i_pop) r_rp <= r_rp + PW'(1);
            r_cnt <= r_cnt + (PW+1)'(i_push.count) - (PW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

@@ rtl/core/tsp_back.sv @@
`default_nettype none
module tsp_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tsp_pkg::t_out_word i_data,
    input  wire logic               i_valid,
    output logic                    o_pop,
    output logic                    o_out_valid,
    output tsp_pkg::t_out_word      o_out_data,
    input  wire logic               i_out_stall
);
    logic               r_valid;
    tsp_pkg::t_out_word r_data;

    // advance when the register is empty or its word is taken
    assign o_pop = i_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_data <= i_data;
    end
endmodule
`default_nettype wire

@@ rtl/core/tar_stream_header_parser_unit.sv @@
// Takes one archive byte per cycle, back to back while not stalled; the parser state is
// registered. A result word is written into the queue when its byte is accepted and then
// passes the output register. Throughput: one byte per cycle in, one result word per cycle
// out while not stalled, through a 4-word queue. The input stalls only while the queue lacks
// room for two words. Reset is synchronous, active low; after an error or the end marker
// bytes are dropped until reset.
`default_nettype none
module tar_stream_header_parser_unit #(
    parameter int SIZE_BITS = tsp_pkg::SIZE_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire tsp_pkg::t_in_word  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output tsp_pkg::t_out_word      o_out_data,
    input  wire logic               i_out_stall
);
    tsp_pkg::t_push     push;
    tsp_pkg::t_out_word q_data;
    logic               q_valid, q_pop, no_room, accept;

    assign o_in_stall = no_room;
    assign accept = i_in_valid && !no_room;

    tsp_front #(.SIZE_BITS(SIZE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_word(i_in_data), .o_push(push)
    );

    tsp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_pop(q_pop),
        .o_data(q_data), .o_valid(q_valid), .o_no_room(no_room)
    );

    tsp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_data(q_data), .i_valid(q_valid),
        .o_pop(q_pop), .o_out_valid(o_out_valid), .o_out_data(o_out_data),
        .i_out_stall(i_out_stall)
    );

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count != 2'd0 |-> accept)
        else $error("result pushed without an accepted byte");

    a_second_is_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.count == 2'd2 |-> push.ev1.event_kind == tsp_pkg::KIND_ERROR
                               && !push.ev0.is_final && push.ev1.is_final)
        else $error("bad second result of a byte");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.event_kind != 2'd3)
        else $error("invalid event kind");
endmodule
`default_nettype wire

@@ test/tar_stream_header_parser_unit_tb.sv @@
`timescale 1ns / 100ps
module tar_stream_header_parser_unit_tb;

    typedef enum logic [2:0] {
        PH_HEADER, PH_SKIP, PH_PAXLEN, PH_PAXKEY, PH_PAXVAL, PH_ENDCHK
    } t_phase;

    localparam logic [63:0] SZ_MAX  = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] LEN_MAX = 64'h0000_0000_00FF_FFFF;
    localparam logic [63:0] CHK_MAX = 64'h0000_0000_00FF_FFFF;
    localparam logic [7:0]  CH_0 = 8'h30, CH_7 = 8'h37, CH_9 = 8'h39;
    localparam logic [7:0]  CH_X = 8'h78, CH_G = 8'h67, CH_EQ = 8'h3d, CH_SP = 8'h20;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    tsp_pkg::t_in_word  in_data = '0;
    logic               in_stall;
    logic               out_valid;
    tsp_pkg::t_out_word out_data;
    logic               out_stall = 1'b0;

    tar_stream_header_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- parser state of the prediction ----------------
    t_phase      ph;
    int unsigned blk_idx;
    logic [63:0] arc_off, chk_val, hsize, skip_left, rec_len, pax_val, local_sz, global_sz;
    logic [16:0] byte_sum;
    bit          f_nonzero, f_magicbad, f_chkend, f_sizeend, chk_go, size_go, halted;
    logic [7:0]  type_c;
    int unsigned key_m;

    tsp_pkg::t_out_word expected_events[$];
    int                 mismatches = 0;

    function automatic logic [63:0] sat_mac(logic [63:0] acc, logic [63:0] mul,
                                            logic [63:0] d, logic [63:0] maxv);
        if (d > maxv || acc > (maxv - d) / mul) return maxv;
        return acc * mul + d;
    endfunction

    function automatic logic [63:0] round_blk(logic [63:0] s);
        logic [63:0] r;
        r = s % 512;
        if (r == 0) return s;
        if (s > SZ_MAX - (512 - r)) return SZ_MAX;
        return s + (512 - r);
    endfunction

    function automatic logic [7:0] magic_at(int k);
        case (k)
            0: return 8'h75;
            1: return 8'h73;
            2: return 8'h74;
            3: return 8'h61;
            4: return 8'h72;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] key_at(int unsigned k);
        case (k)
            0: return 8'h73;
            1: return 8'h69;
            2: return 8'h7a;
            default: return 8'h65;
        endcase
    endfunction

    function automatic tsp_pkg::t_out_word mk_event(logic [1:0] kind, logic [63:0] etype,
                                                    logic [63:0] size, logic [63:0] off,
                                                    logic [2:0] err);
        tsp_pkg::t_out_word w;
        w.event_kind  = kind;
        w.entry_type  = etype[3:0];
        w.entry_size  = size[47:0];
        w.data_offset = off[47:0];
        w.error_code  = err;
        w.is_final    = 1'b0;
        return w;
    endfunction

    task automatic clear_header();
        ph = PH_HEADER;
        blk_idx = 0;
        byte_sum = '0;
        chk_val = 0;
        hsize = 0;
        {f_nonzero, f_magicbad, f_chkend, f_sizeend, chk_go, size_go} = '0;
        type_c = 8'h00;
    endtask

    task automatic reset_parser();
        clear_header();
        arc_off = 0;
        skip_left = 0;
        rec_len = 0;
        key_m = 0;
        pax_val = 0;
        local_sz = 0;
        global_sz = 0;
        halted = 1'b0;
    endtask

    task automatic start_record();
        ph = PH_PAXLEN;
        rec_len = 0;
        pax_val = 0;
        key_m = 0;
    endtask

    task automatic commit_size();
        if (key_m == 4 || key_m == 6) begin
            if (type_c == CH_X) local_sz = pax_val;
            else global_sz = pax_val;
        end
    endtask

    task automatic octal_in(inout logic [63:0] v, inout bit go, inout bit ended,
                            input logic [7:0] b, input logic [63:0] maxv);
        if (ended) return;
        if (!go && (b == CH_SP || (b >= 8'd9 && b <= 8'd13))) return;
        if (b >= CH_0 && b <= CH_7) begin
            go = 1'b1;
            v = sat_mac(v, 8, 64'(b) - 64'd48, maxv);
        end else begin
            ended = 1'b1;
        end
    endtask

    task automatic header_in(int unsigned i, logic [7:0] b);
        if (b != 0) f_nonzero = 1'b1;
        if (i >= 148 && i < 156) begin
            byte_sum = byte_sum + 17'd32;
            octal_in(chk_val, chk_go, f_chkend, b, CHK_MAX);
        end else begin
            byte_sum = byte_sum + 17'(b);
        end
        if (i >= 124 && i < 136) octal_in(hsize, size_go, f_sizeend, b, SZ_MAX);
        if (i == 156) type_c = b;
        if (i >= 257 && i < 263 && b != magic_at(i - 257)) f_magicbad = 1'b1;
    endtask

    task automatic pax_in(input logic [7:0] b, output logic [2:0] e);
        bit digit;
        digit = (b >= CH_0 && b <= CH_9);
        e = tsp_pkg::ERR_NONE;
        if (ph == PH_PAXLEN) begin
            if (digit) begin
                rec_len = sat_mac(rec_len, 10, 64'(b) - 64'd48, LEN_MAX);
                if (pax_val < SZ_MAX) pax_val++;
            end else if (pax_val + 1 >= rec_len) begin
                e = tsp_pkg::ERR_PAX;
            end else begin
                rec_len = rec_len - (pax_val + 1);
                pax_val = 0;
                key_m = 0;
                ph = PH_PAXKEY;
            end
        end else if (ph == PH_PAXKEY) begin
            rec_len--;
            if (b == CH_EQ) begin
                key_m = (key_m == 4) ? 4 : 5;
                pax_val = 0;
                ph = PH_PAXVAL;
                if (rec_len == 0) begin
                    commit_size();
                    start_record();
                end
            end else begin
                if (key_m < 4 && b == key_at(key_m)) key_m++;
                else key_m = 5;
                if (rec_len == 0) e = tsp_pkg::ERR_PAX;
            end
        end else begin
            if (key_m == 4) begin
                if (digit) pax_val = sat_mac(pax_val, 10, 64'(b) - 64'd48, SZ_MAX);
                else key_m = 6;
            end
            rec_len--;
            if (rec_len == 0) begin
                commit_size();
                start_record();
            end
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic last);
        logic [63:0]        cur, pad, size;
        logic [2:0]         err;
        tsp_pkg::t_out_word ev[2];
        int                 n;
        if (halted) return;
        n = 0;
        err = tsp_pkg::ERR_NONE;
        cur = arc_off;
        arc_off = (cur + 1) & SZ_MAX;
        if (ph == PH_HEADER || ph == PH_ENDCHK) begin
            header_in(blk_idx, b);
            if (blk_idx < 511) begin
                blk_idx++;
            end else if (ph == PH_ENDCHK) begin
                if (f_nonzero) err = tsp_pkg::ERR_NO_END;
                else ev[n++] = mk_event(tsp_pkg::KIND_END, 0, 0, 0, tsp_pkg::ERR_NONE);
                halted = 1'b1;
            end else if (!f_nonzero) begin
                clear_header();
                ph = PH_ENDCHK;
            end else if ({47'b0, byte_sum} != chk_val) begin
                err = tsp_pkg::ERR_CHECKSUM;
            end else if (f_magicbad) begin
                err = tsp_pkg::ERR_MAGIC;
            end else if (type_c == CH_X || type_c == CH_G) begin
                skip_left = round_blk(hsize);
                start_record();
                if (skip_left == 0) clear_header();
            end else if (type_c >= CH_0 && type_c <= CH_9) begin
                size = (local_sz != 0) ? local_sz : (global_sz != 0) ? global_sz : hsize;
                ev[n++] = mk_event(tsp_pkg::KIND_ENTRY, 64'(type_c) - 64'd48, size, cur + 1,
                                   tsp_pkg::ERR_NONE);
                local_sz = 0;
                skip_left = round_blk(size);
                if (skip_left == 0) clear_header();
                else ph = PH_SKIP;
            end else begin
                err = tsp_pkg::ERR_TYPE;
            end
        end else if (ph == PH_SKIP) begin
            skip_left--;
            if (skip_left == 0) clear_header();
        end else begin
            pad = round_blk(hsize) - hsize;
            pax_in(b, err);
            skip_left--;
            if (err == tsp_pkg::ERR_NONE && skip_left == pad) begin
                // pax region done: unfinished key or length is an error
                if (ph == PH_PAXKEY || (ph == PH_PAXLEN && pax_val != 0)) begin
                    err = tsp_pkg::ERR_PAX;
                end else begin
                    if (ph == PH_PAXVAL) commit_size();
                    if (pad == 0) clear_header();
                    else begin
                        ph = PH_SKIP;
                        skip_left = pad;
                    end
                end
            end
        end
        if (err != tsp_pkg::ERR_NONE) begin
            ev[n++] = mk_event(tsp_pkg::KIND_ERROR, 0, 0, 0, err);
            halted = 1'b1;
        end
        if (!halted && last) begin
            ev[n++] = mk_event(tsp_pkg::KIND_ERROR, 0, 0, 0, tsp_pkg::ERR_BOUNDS);
            halted = 1'b1;
        end
        if (n > 0) ev[n-1].is_final = 1'b1;
        for (int k = 0; k < n; k++) expected_events.push_back(ev[k]);
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $time);
        mismatches++;
    endtask

    task automatic check_event(tsp_pkg::t_out_word got);
        tsp_pkg::t_out_word exp;
        if (expected_events.size() == 0) begin
            report_mismatch("unexpected word", 64'(got), 0);
            return;
        end
        exp = expected_events.pop_front();
        if (got.event_kind != exp.event_kind)
            report_mismatch("event_kind", 64'(got.event_kind), 64'(exp.event_kind));
        if (got.entry_type != exp.entry_type)
            report_mismatch("entry_type", 64'(got.entry_type), 64'(exp.entry_type));
        if (got.entry_size != exp.entry_size)
            report_mismatch("entry_size", 64'(got.entry_size), 64'(exp.entry_size));
        if (got.data_offset != exp.data_offset)
            report_mismatch("data_offset", 64'(got.data_offset), 64'(exp.data_offset));
        if (got.error_code != exp.error_code)
            report_mismatch("error_code", 64'(got.error_code), 64'(exp.error_code));
        if (got.is_final != exp.is_final)
            report_mismatch("is_final", 64'(got.is_final), 64'(exp.is_final));
    endtask

    int hold_request = 0;
    int hold_left = 0;
    int mode_left = 0;
    int stall_pct = 0;

    always @(posedge i_clk) begin
        if (out_valid && !out_stall) check_event(out_data);
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (mode_left <= 0) begin
                mode_left = $urandom_range(20, 300);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 30;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            mode_left--;
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------- archive building and sending ----------------
    logic [7:0]  arc_bytes[$];
    logic [63:0] stim_local = 0, stim_global = 0;
    int          burst_left = 0;
    int          bytes_sent = 0, entries_built = 0, pax_built = 0;
    string       closing_case = "none";

    task automatic send_byte(input logic [7:0] b, input logic last);
        in_valid <= 1'b1;
        in_data  <= {b, last};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        parse_byte(b, last);
        bytes_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(500, 3000)
                                                     : $urandom_range(0, 60);
        end
    endtask

    task automatic flush_stream(input bit mark_last);
        logic [7:0] b;
        while (arc_bytes.size() > 0) begin
            b = arc_bytes.pop_front();
            send_byte(b, mark_last && arc_bytes.size() == 0);
        end
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic put_header(logic [7:0] tc, logic [63:0] size, bit bad_chk,
                              bit bad_magic, bit space_pad);
        logic [7:0]  h[512];
        logic [63:0] s;
        int          sum, ndig, k;
        for (k = 0; k < 512; k++) h[k] = 8'h00;
        for (k = 0; k < $urandom_range(1, 99); k++) h[k] = $urandom_range(1, 255);
        ndig = (size >= 64'h2_0000_0000) ? 12 : 11;
        s = size;
        for (k = ndig - 1; k >= 0; k--) begin
            h[124+k] = CH_0 + 8'(s % 8);
            s = s / 8;
        end
        if (ndig == 11) h[135] = space_pad ? CH_SP : 8'h00;
        if (space_pad)
            for (k = 0; k < ndig - 1 && h[124+k] == CH_0; k++) h[124+k] = CH_SP;
        h[156] = tc;
        for (k = 0; k < 6; k++) h[257+k] = magic_at(k);
        h[263] = CH_0;
        h[264] = CH_0;
        if (bad_magic) h[257 + $urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
        sum = 0;
        for (k = 0; k < 512; k++) sum += (k >= 148 && k < 156) ? 32 : int'(h[k]);
        if (bad_chk) sum += $urandom_range(1, 7);
        for (k = 5; k >= 0; k--) begin
            h[148+k] = CH_0 + 8'(sum % 8);
            sum = sum / 8;
        end
        h[154] = 8'h00;
        h[155] = CH_SP;
        for (k = 0; k < 512; k++) arc_bytes.push_back(h[k]);
    endtask

    task automatic put_payload(logic [63:0] n);
        logic [63:0] padded;
        padded = round_blk(n);
        for (logic [63:0] k = 0; k < padded; k++) arc_bytes.push_back($urandom_range(0, 255));
    endtask

    task automatic put_entry(int digit, logic [63:0] hdr_size);
        logic [63:0] len;
        len = (stim_local != 0) ? stim_local : (stim_global != 0) ? stim_global : hdr_size;
        stim_local = 0;
        put_header(CH_0 + 8'(digit), hdr_size, 0, 0, $urandom_range(0, 1));
        put_payload(len);
        entries_built++;
    endtask

    task automatic put_pax(logic [7:0] tc, string recs);
        put_header(tc, recs.len(), 0, 0, $urandom_range(0, 1));
        for (int k = 0; k < recs.len(); k++) arc_bytes.push_back(recs[k]);
        for (int k = recs.len(); k < round_blk(recs.len()); k++)
            arc_bytes.push_back($urandom_range(0, 255));
        pax_built++;
    endtask

    function automatic int dec_digits(int v);
        int d;
        d = 1;
        while (v >= 10) begin
            v = v / 10;
            d++;
        end
        return d;
    endfunction

    function automatic string pax_rec(string key, string val);
        string body;
        int    d;
        body = {" ", key, "=", val, "\n"};
        d = 1;
        while (dec_digits(body.len() + d) != d) d++;
        return {$sformatf("%0d", body.len() + d), body};
    endfunction

    function automatic string rand_text(int n);
        string s;
        s = "";
        for (int k = 0; k < n; k++) s = $sformatf("%s%c", s, 8'($urandom_range(97, 122)));
        return s;
    endfunction

    // ---------------- tests ----------------
    task automatic test_entry_types();
        logic [63:0] sizes[10] = '{0, 1, 511, 512, 513, 1023, 1024, 2047, 0, 100};
        for (int t = 0; t < 10; t++) put_entry(t, sizes[t]);
        flush_stream(0);
    endtask

    task automatic test_pax_sizes();
        put_pax(CH_X, {pax_rec("path", "abc"), pax_rec("size", "700")});
        stim_local = 700;
        put_entry(0, 5);
        put_pax(CH_G, pax_rec("size", "300"));
        stim_global = 300;
        put_entry(1, 9);
        put_entry(2, 9);
        // near misses of the key fall back to the global size
        put_pax(CH_X, {pax_rec("sizes", "5"), pax_rec("siz", "4"), pax_rec("xsize", "3")});
        put_entry(3, 7);
        put_pax(CH_X, pax_rec("size", "12a"));
        stim_local = 12;
        put_entry(4, 7);
        put_pax(CH_X, pax_rec("size", ""));
        put_entry(5, 7);
        put_pax(CH_G, pax_rec("size", "0"));
        stim_global = 0;
        put_entry(6, 40);
        put_header(CH_X, 0, 0, 0, 0);
        put_entry(7, 3);
        // region ends inside the value: the partial value still counts
        put_pax(CH_X, "20 size=33");
        stim_local = 33;
        put_entry(8, 1);
        flush_stream(0);
    endtask

    task automatic test_random_archive(int members);
        string recs;
        int    v;
        for (int m = 0; m < members; m++) begin
            case ($urandom_range(0, 19)) inside
                [0:12]: put_entry($urandom_range(0, 9),
                                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4000)
                                                              : $urandom_range(0, 1200));
                default: begin
                    recs = "";
                    v = -1;
                    for (int r = 0; r < $urandom_range(0, 3); r++)
                        recs = {recs, pax_rec(rand_text($urandom_range(1, 6)),
                                              rand_text($urandom_range(0, 8)))};
                    if ($urandom_range(0, 3) != 0) begin
                        v = $urandom_range(0, 2000);
                        recs = {recs, pax_rec("size", $sformatf("%0d", v))};
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        put_pax(CH_G, recs);
                        if (v >= 0) stim_global = v;
                    end else begin
                        put_pax(CH_X, recs);
                        if (v >= 0) stim_local = v;
                    end
                end
            endcase
            if (arc_bytes.size() > 4096) flush_stream(0);
        end
        flush_stream(0);
    endtask

    task automatic test_backpressure();
        hold_request = 4000;
        for (int k = 0; k < 10; k++) put_entry($urandom_range(0, 9), 0);
        flush_stream(0);
    endtask

    task automatic test_drain_pause();
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        put_entry(9, 0);
        flush_stream(0);
    endtask

    task automatic test_closing_case();
        logic [7:0] tc;
        case ($urandom_range(0, 7))
            0: begin
                closing_case = "end of archive";
                for (int k = 0; k < 1024; k++) arc_bytes.push_back(8'h00);
            end
            1: begin
                closing_case = "missing end block";
                for (int k = 0; k < 512; k++) arc_bytes.push_back(8'h00);
                put_header(CH_0, 0, 0, 0, 0);
            end
            2: begin
                closing_case = "bad checksum";
                put_header(CH_0, 0, 1, 0, 0);
            end
            3: begin
                closing_case = "bad magic";
                put_header(CH_0, 0, 0, 1, 0);
            end
            4: begin
                closing_case = "pax record without equals";
                put_pax(CH_X, "8 abcde\n");
            end
            5: begin
                closing_case = "unknown type";
                do tc = $urandom_range(0, 255);
                while ((tc >= CH_0 && tc <= CH_9) || tc == CH_X || tc == CH_G);
                put_header(tc, 0, 0, 0, 0);
            end
            6: begin
                closing_case = "saturated pax size, last byte on header";
                put_pax(CH_X, pax_rec("size", "99999999999999999999"));
                put_header(CH_0, 5, 0, 0, 0);
            end
            default: begin
                closing_case = "largest octal size, input ends in data";
                put_header(CH_0 + 8'($urandom_range(0, 9)), 64'hF_FFFF_FFFF, 0, 0, 0);
                for (int k = 0; k < 3; k++) arc_bytes.push_back($urandom_range(0, 255));
            end
        endcase
        flush_stream(1);
    endtask

    initial begin
        reset_parser();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_entry_types();
        test_pax_sizes();
        test_backpressure();
        test_random_archive(150);
        test_drain_pause();
        test_random_archive(20);
        test_closing_case();
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("sent %0d archive bytes: %0d entries, %0d pax headers", bytes_sent,
                 entries_built, pax_built);
        $display("closing case: %s", closing_case);
        if (mismatches == 0 && expected_events.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d words never arrived", mismatches,
                     expected_events.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
